// ===== sv/ptc_pkg.sv =====
package ptc_pkg;

	// register reset and fixed conversion constants
	localparam logic [27:0] CLOCK_RESET  = 28'd24000000;
	localparam int          NS_PER_SEC   = 1000000000;
	localparam int          PCT_FULL     = 100;

	// default prescaler range and counter width
	localparam int MAX_PRESCALE_DEF = 10;
	localparam int COUNTER_BITS_DEF = 16;

	// field widths
	localparam int CLK_W   = 28;
	localparam int NS_W    = 32;
	localparam int PCT_W   = 8;
	localparam int PRE_W   = 4;
	localparam int CNT_W   = 22;
	localparam int IN_W    = 104;
	localparam int OUT_W   = 56;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_FREQ   = 2'd1,
		ST_ZERO_PERIOD = 2'd2
	} status_t;

endpackage

// ===== sv/ptc_div.sv =====
module ptc_div #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [PW-1:0] out_pay
);

	// one quotient bit per stage, quotient shifts in where numerator bits leave
	logic [NW-1:0] num_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [PW-1:0] pay_s [NW];
	logic          vld_s [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [NW-1:0] n_in;
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [PW-1:0] p_in;
		logic          v_in;
		logic [DW:0]   trial;
		logic [DW:0]   diff;

		if (i == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign d_in = den;
			assign p_in = pay;
			assign v_in = in_valid;
		end else begin : g_next
			assign n_in = num_s[i-1];
			assign r_in = rem_s[i-1];
			assign d_in = den_s[i-1];
			assign p_in = pay_s[i-1];
			assign v_in = vld_s[i-1];
		end

		// trial subtract, sign bit says whether it fits
		assign trial = {r_in, n_in[NW-1]};
		assign diff  = trial - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i] <= {n_in[NW-2:0], ~diff[DW]};
				rem_s[i] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
				den_s[i] <= d_in;
				pay_s[i] <= p_in;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo       = num_s[NW-1];
	assign out_pay   = pay_s[NW-1];

endmodule

// ===== sv/pwm_timing_calculator.sv =====
// channel   | handshake                    | payload
// s_axis    | s_axis_tvalid/s_axis_tready  | tuser command, tdata request fields
// m_axis    | m_axis_tvalid/m_axis_tready  | tdata result fields
// cfg       | cfg_valid/cfg_ready          | cfg_data source clock in Hz
//
// one request per cycle while m_axis is not stalled; the path runs through two bit-serial
// divider pipelines (30 and 64 stages) plus seven register stages.
// the divisions by 1e9 and by 100 use a reciprocal multiply and one correction step.
// arst_n clears all valid bits and loads the source clock with 24 MHz.
// a stall on m_axis freezes every stage at once, so nothing is lost.
module pwm_timing_calculator #(
	parameter int MAX_PRESCALE = ptc_pkg::MAX_PRESCALE_DEF,
	parameter int COUNTER_BITS = ptc_pkg::COUNTER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// period_req, duty_ns, freq_hz, pct_req
	input  logic [ptc_pkg::IN_W-1:0]   s_axis_tdata,
	// command
	input  logic                       s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status, prescale, period_count, duty_count, period_too_long,
	// duty_clamped, zero fill
	output logic [ptc_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ptc_pkg::CLK_W-1:0]  cfg_data
);
	import ptc_pkg::*;

	localparam logic [32:0] LIMIT = 33'((64'd1 << COUNTER_BITS) - 64'd1);
	localparam int          AW    = 30;
	localparam int          APW   = 1 + NS_W + NS_W + 7 + 1;
	localparam int          GPW   = 2 + PRE_W + 1 + NS_W;
	// scaled reciprocals, top 32 product bits times these, shifted down by 33
	localparam logic [31:0] CYC_RECIP = 32'((64'd1 << 61) / 64'(NS_PER_SEC));
	localparam logic [31:0] PCT_RECIP = 32'((64'd1 << 38) / 64'(PCT_FULL));

	logic              en;
	logic [CLK_W-1:0]  clk_hz_q;

	// one global advance, an empty output register or a taken transfer
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// source clock register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLOCK_RESET;
		end else if (cfg_valid) begin
			clk_hz_q <= cfg_data;
		end
	end

	// request unpack and percent clamp
	logic [NS_W-1:0] in_per, in_duty, in_freq;
	logic [PCT_W-1:0] in_pct;
	logic [6:0]       pct_c;
	assign in_per  = s_axis_tdata[31:0];
	assign in_duty = s_axis_tdata[63:32];
	assign in_freq = s_axis_tdata[95:64];
	assign in_pct  = s_axis_tdata[103:96];
	assign pct_c   = (in_pct > 8'(PCT_FULL)) ? 7'(PCT_FULL) : in_pct[6:0];

	// period from frequency: 1e9 / freq_hz
	logic           a_vld;
	logic [AW-1:0]  a_quo;
	logic [APW-1:0] a_pay;
	ptc_div #(.NW(AW), .DW(NS_W), .PW(APW)) u_div_freq (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.num      (AW'(NS_PER_SEC)),
		.den      (in_freq),
		.pay      ({s_axis_tuser, in_per, in_duty, pct_c, in_freq == '0}),
		.out_valid(a_vld),
		.quo      (a_quo),
		.out_pay  (a_pay)
	);

	logic            a_cmd, a_fz;
	logic [NS_W-1:0] a_per, a_duty, per_sel;
	logic [6:0]      a_pct;
	status_t         st_a;
	assign {a_cmd, a_per, a_duty, a_pct, a_fz} = a_pay;
	assign per_sel = a_cmd ? NS_W'(a_quo) : a_per;

	always_comb begin
		if (a_cmd && a_fz) begin
			st_a = ST_ZERO_FREQ;
		end else if (per_sel == '0) begin
			st_a = ST_ZERO_PERIOD;
		end else begin
			st_a = ST_OK;
		end
	end

	// stage 1: duty product and clock cycle product
	logic            v_s1, cmd_s1;
	logic [36:0]     prod_pct_s1;
	logic [59:0]     prod_clk_s1;
	logic [NS_W-1:0] per_s1, duty_s1;
	status_t         status_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= a_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_pct_s1 <= 37'(a_quo) * 37'(a_pct);
			prod_clk_s1 <= 60'(clk_hz_q) * 60'(per_sel);
			per_s1      <= per_sel;
			duty_s1     <= a_duty;
			cmd_s1      <= a_cmd;
			status_s1   <= st_a;
		end
	end

	// stage 2: quotient estimates, at most one below the true quotient
	logic            v_s2, cmd_s2;
	logic [30:0]     cyc_est_s2, pct_est_s2;
	logic [59:0]     prod_clk_s2;
	logic [36:0]     prod_pct_s2;
	logic [NS_W-1:0] per_s2, duty_s2;
	logic [1:0]      status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cyc_est_s2  <= 31'((64'(prod_clk_s1[59:28]) * 64'(CYC_RECIP)) >> 33);
			pct_est_s2  <= 31'((64'(prod_pct_s1[36:5]) * 64'(PCT_RECIP)) >> 33);
			prod_clk_s2 <= prod_clk_s1;
			prod_pct_s2 <= prod_pct_s1;
			per_s2      <= per_s1;
			duty_s2     <= duty_s1;
			cmd_s2      <= cmd_s1;
			status_s2   <= status_s1;
		end
	end

	// stage 3: estimates multiplied back by their divisors
	logic            v_s3, cmd_s3;
	logic [30:0]     cyc_est_s3, pct_est_s3;
	logic [59:0]     prod_clk_s3, cyc_back_s3;
	logic [36:0]     prod_pct_s3, pct_back_s3;
	logic [NS_W-1:0] per_s3, duty_s3;
	logic [1:0]      status_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cyc_back_s3 <= 60'(cyc_est_s2) * 60'(NS_PER_SEC);
			pct_back_s3 <= 37'(pct_est_s2) * 37'(PCT_FULL);
			cyc_est_s3  <= cyc_est_s2;
			pct_est_s3  <= pct_est_s2;
			prod_clk_s3 <= prod_clk_s2;
			prod_pct_s3 <= prod_pct_s2;
			per_s3      <= per_s2;
			duty_s3     <= duty_s2;
			cmd_s3      <= cmd_s2;
			status_s3   <= status_s2;
		end
	end

	// stage 4: bump the estimate when the remainder still holds a divisor
	logic            v_s4, cmd_s4;
	logic [NS_W-1:0] cycles_s4, pduty_s4, per_s4, duty_s4;
	logic [1:0]      status_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cycles_s4 <= (prod_clk_s3 - cyc_back_s3 >= 60'(NS_PER_SEC)) ?
				32'(cyc_est_s3) + 32'd1 : 32'(cyc_est_s3);
			pduty_s4  <= (prod_pct_s3 - pct_back_s3 >= 37'(PCT_FULL)) ?
				32'(pct_est_s3) + 32'd1 : 32'(pct_est_s3);
			per_s4    <= per_s3;
			duty_s4   <= duty_s3;
			cmd_s4    <= cmd_s3;
			status_s4 <= status_s3;
		end
	end

	logic [NS_W-1:0]  duty_sel, pc_sel;
	logic [PRE_W-1:0] pre_sel;
	logic             fit;
	assign duty_sel = cmd_s4 ? pduty_s4 : duty_s4;

	// smallest prescale whose shifted count lands in 1..limit
	always_comb begin
		logic [NS_W-1:0] s;
		pre_sel = PRE_W'(MAX_PRESCALE);
		pc_sel  = cycles_s4 >> MAX_PRESCALE;
		fit     = 1'b0;
		for (int p = MAX_PRESCALE; p >= 0; p--) begin
			s = cycles_s4 >> p;
			if (s != '0 && 33'(s) <= LIMIT) begin
				pre_sel = PRE_W'(p);
				pc_sel  = s;
				fit     = 1'b1;
			end
		end
	end

	// stage 5: prescale choice
	logic             v_s5, found_s5;
	logic [PRE_W-1:0] pre_s5;
	logic [NS_W-1:0]  pcount_s5, duty_s5, per_s5;
	logic [1:0]       status_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s5    <= pre_sel;
			pcount_s5 <= pc_sel;
			found_s5  <= fit;
			duty_s5   <= duty_sel;
			per_s5    <= per_s4;
			status_s5 <= status_s4;
		end
	end

	// stage 6: period count times duty
	logic             v_s6, found_s6;
	logic [63:0]      prod_s6;
	logic [PRE_W-1:0] pre_s6;
	logic [NS_W-1:0]  pcount_s6, per_s6;
	logic [1:0]       status_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s6   <= 64'(pcount_s5) * 64'(duty_s5);
			pre_s6    <= pre_s5;
			pcount_s6 <= pcount_s5;
			found_s6  <= found_s5;
			per_s6    <= per_s5;
			status_s6 <= status_s5;
		end
	end

	// duty count: product / period in ns
	logic           g_vld;
	logic [63:0]    g_quo;
	logic [GPW-1:0] g_pay;
	ptc_div #(.NW(64), .DW(NS_W), .PW(GPW)) u_div_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.num      (prod_s6),
		.den      (per_s6),
		.pay      ({status_s6, pre_s6, found_s6, pcount_s6}),
		.out_valid(g_vld),
		.quo      (g_quo),
		.out_pay  (g_pay)
	);

	logic [1:0]       g_status;
	logic [PRE_W-1:0] g_pre;
	logic             g_found, clamp, ok;
	logic [NS_W-1:0]  g_pcount, dcount;
	assign {g_status, g_pre, g_found, g_pcount} = g_pay;
	assign clamp  = g_quo > 64'(g_pcount);
	assign dcount = clamp ? g_pcount : g_quo[31:0];
	assign ok     = g_status == ST_OK;

	// stage 7: output register, error results carry zero fields
	logic             v_s7, too_long_s7, clamped_s7;
	logic [1:0]       status_s7;
	logic [PRE_W-1:0] pre_s7;
	logic [CNT_W-1:0] pcount_s7, dcount_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= g_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s7   <= g_status;
			pre_s7      <= ok ? g_pre : '0;
			pcount_s7   <= ok ? g_pcount[CNT_W-1:0] : '0;
			dcount_s7   <= ok ? dcount[CNT_W-1:0] : '0;
			too_long_s7 <= ok && !g_found;
			clamped_s7  <= ok && clamp;
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata  = {4'b0, clamped_s7, too_long_s7, dcount_s7, pcount_s7,
		pre_s7, status_s7};

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ptc_pkg::*;

	localparam int LATENCY   = 101;
	localparam int MAX_PRE   = 10;
	localparam logic [63:0] CNT_LIMIT = 64'hffff;
	localparam int N_RANDOM  = 1000;

	typedef struct packed {
		logic                 duty_clamped;
		logic                 period_too_long;
		logic [CNT_W-1:0]     duty_count;
		logic [CNT_W-1:0]     period_count;
		logic [PRE_W-1:0]     prescale;
		status_t              status;
	} timing_t;

	typedef struct {
		logic                 command;
		logic [NS_W-1:0]      period_req;
		logic [NS_W-1:0]      duty_ns;
		logic [NS_W-1:0]      freq_hz;
		logic [PCT_W-1:0]     pct_req;
		bit                   known;
		timing_t              want;
	} request_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CLK_W-1:0]  cfg_data = '0;

	logic [CLK_W-1:0]  src_clock_hz;
	timing_t           pending_timing[$];
	int                mismatches = 0;
	bit                drain_hold = 1'b0;
	bit                quiet_rx = 1'b0;
	bit                quiet_tx = 1'b0;

	pwm_timing_calculator i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// work out prescaler, counts and flags for one request
	function automatic timing_t calc_timing(request_t r);
		timing_t     t;
		logic [63:0] per, dut, pct, cyc, s, pcnt, dcnt;
		bit          found;
		t = '0;
		per = r.period_req;
		dut = r.duty_ns;
		if (r.command) begin
			if (r.freq_hz == 0) begin
				t.status = ST_ZERO_FREQ;
				return t;
			end
			pct = (r.pct_req > PCT_FULL) ? 64'(PCT_FULL) : 64'(r.pct_req);
			per = 64'(NS_PER_SEC) / 64'(r.freq_hz);
			dut = per * pct / 64'(PCT_FULL);
		end
		if (per == 0) begin
			t.status = ST_ZERO_PERIOD;
			return t;
		end
		cyc = (64'(src_clock_hz) * per / 64'(NS_PER_SEC)) & 64'hffffffff;
		found = 1'b0;
		pcnt = cyc >> MAX_PRE;
		t.prescale = PRE_W'(MAX_PRE);
		for (int p = 0; p <= MAX_PRE; p++) begin
			s = cyc >> p;
			if (!found && s > 0 && s <= CNT_LIMIT) begin
				found = 1'b1;
				pcnt = s;
				t.prescale = PRE_W'(p);
			end
		end
		dcnt = pcnt * dut / per;
		if (dcnt > pcnt) begin
			dcnt = pcnt;
			t.duty_clamped = 1'b1;
		end
		t.status = ST_OK;
		t.period_count = pcnt[CNT_W-1:0];
		t.duty_count = dcnt[CNT_W-1:0];
		t.period_too_long = !found;
		return t;
	endfunction

	// present one request and wait for its transfer
	task automatic send_request(request_t r);
		while (!quiet_tx && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.command;
		s_axis_tdata <= {r.pct_req, r.freq_hz, r.duty_ns, r.period_req};
		pending_timing.push_back(r.known ? r.want : calc_timing(r));
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_timing.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_clock(logic [CLK_W-1:0] hz);
		cfg_valid <= 1'b1;
		cfg_data <= hz;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		src_clock_hz = hz;
	endtask

	function automatic request_t mk(logic c, logic [31:0] per, logic [31:0] dut,
			logic [31:0] f, logic [7:0] pct);
		request_t r;
		r.command = c; r.period_req = per; r.duty_ns = dut;
		r.freq_hz = f; r.pct_req = pct; r.known = 1'b0; r.want = '0;
		return r;
	endfunction

	function automatic request_t rand_request();
		request_t r;
		int       k;
		r = mk(1'($urandom_range(1)), $urandom, $urandom, $urandom,
			8'($urandom_range(255)));
		k = $urandom_range(9);
		// mostly periods that land in the prescaler range
		if (k < 4) begin
			r.period_req = $urandom_range(20_000_000, 1);
			r.duty_ns = $urandom_range(r.period_req + r.period_req / 4);
		end else if (k < 7) begin
			r.freq_hz = $urandom_range(2_000_000, 1);
		end else if (k == 7) begin
			r.freq_hz = $urandom_range(3);
			r.period_req = $urandom_range(3);
		end
		return r;
	endfunction

	// result check against the oldest expectation
	always @(posedge clk) begin
		timing_t got, exp_t;
		if (m_axis_tvalid && m_axis_tready) begin
			got = timing_t'(m_axis_tdata[$bits(timing_t)-1:0]);
			if (pending_timing.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer %h", got);
			end else begin
				exp_t = pending_timing.pop_front();
				if (got !== exp_t || m_axis_tdata[OUT_W-1:$bits(timing_t)] !== '0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch: st %0d/%0d pre %0d/%0d pc %0d/%0d",
							exp_t.status, got.status, exp_t.prescale, got.prescale,
							exp_t.period_count, got.period_count);
						$display("  dc %0d/%0d tl %0d/%0d cl %0d/%0d",
							exp_t.duty_count, got.duty_count,
							exp_t.period_too_long, got.period_too_long,
							exp_t.duty_clamped, got.duty_clamped);
					end
				end
			end
		end
	end

	// receiver: random stalls, a long hold-off and a quiet stretch
	initial begin
		forever begin
			@(posedge clk);
			if (drain_hold) m_axis_tready <= 1'b0;
			else if (quiet_rx) m_axis_tready <= 1'b1;
			else m_axis_tready <= ($urandom_range(99) >= 8);
		end
	end

	// sanity limit on run length
	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus
	initial begin
		request_t dir[$];
		request_t r;
		logic [CLK_W-1:0] clocks[4];
		src_clock_hz = CLOCK_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, plain values after reset
		r = mk(1'b1, 0, 0, 0, 8'd50); r.known = 1; r.want = '0;
		r.want.status = ST_ZERO_FREQ;
		dir.push_back(r);
		r = mk(1'b0, 0, 5, 0, 8'd0); r.known = 1; r.want = '0;
		r.want.status = ST_ZERO_PERIOD;
		dir.push_back(r);
		r = mk(1'b1, 0, 0, 32'hffffffff, 8'd255); r.known = 1; r.want = '0;
		r.want.status = ST_ZERO_PERIOD;
		dir.push_back(r);
		// 1000 ns at 24 MHz gives a period count of 24, half duty
		r = mk(1'b0, 1000, 500, 0, 8'd0); r.known = 1; r.want = '0;
		r.want.period_count = 22'd24; r.want.duty_count = 22'd12;
		dir.push_back(r);
		// too short: the count rounds to zero, no prescale fits
		r = mk(1'b0, 1, 1, 0, 8'd0); r.known = 1; r.want = '0;
		r.want.prescale = PRE_W'(MAX_PRE); r.want.period_too_long = 1'b1;
		dir.push_back(r);
		dir.push_back(mk(1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 8'hff));
		dir.push_back(mk(1'b0, 32'hffffffff, 0, 0, 8'd0));
		dir.push_back(mk(1'b0, 1000, 32'hffffffff, 0, 8'd0));
		dir.push_back(mk(1'b0, 20_000_000, 30_000_000, 0, 8'd0));
		dir.push_back(mk(1'b1, 0, 0, 1, 8'd100));
		dir.push_back(mk(1'b1, 0, 0, 1000, 8'd255));
		dir.push_back(mk(1'b1, 0, 0, 1_000_000_000, 8'd0));
		dir.push_back(mk(1'b1, 0, 0, 50_000, 8'd101));
		dir.push_back(mk(1'b1, 32'hffffffff, 32'hffffffff, 367, 8'd33));
		foreach (dir[i]) send_request(dir[i]);
		wait_drained();

		// long receiver hold-off while requests keep coming
		fork
			begin
				drain_hold = 1'b1;
				repeat (400) @(posedge clk);
				drain_hold = 1'b0;
			end
			for (int i = 0; i < 250; i++) send_request(rand_request());
		join
		wait_drained();

		// several clock settings, extremes included
		clocks[0] = 28'd1; clocks[1] = 28'd200_000_000;
		clocks[2] = 28'hfffffff; clocks[3] = 28'd0;
		foreach (clocks[c]) begin
			write_clock(clocks[c]);
			for (int i = 0; i < 60; i++) send_request(rand_request());
			wait_drained();
		end
		write_clock(28'($urandom_range(200_000_000, 1)));

		// random part with a quiet stretch on both sides
		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_rx = (i >= 300 && i < 600);
			quiet_tx = quiet_rx;
			send_request(rand_request());
		end
		wait_drained();

		if (mismatches == 0 && pending_timing.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ptc_pkg.sv
sv/ptc_div.sv
sv/pwm_timing_calculator.sv
bench/testbench.sv
